### src/ctfu_pkg.sv
`default_nettype none

package ctfu_pkg;

    typedef enum logic [2:0] {
        PH_NORMAL = 3'd0,
        PH_TRAIL  = 3'd1,
        PH_ESCAPE = 3'd2,
        PH_HEX1   = 3'd3,
        PH_HEX2   = 3'd4
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } result_t;

    localparam logic [7:0] SMALL_OFFSET_RESET = 8'd96;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_LOWER_S   = 8'h73;

    localparam logic [7:0] LEAD1_LO = 8'h81;
    localparam logic [7:0] LEAD1_HI = 8'h9F;
    localparam logic [7:0] LEAD2_LO = 8'hE0;
    localparam logic [7:0] LEAD2_HI = 8'hEF;

    function automatic logic is_lead(input logic [7:0] b);
        return ((b >= LEAD1_LO) && (b <= LEAD1_HI)) || ((b >= LEAD2_LO) && (b <= LEAD2_HI));
    endfunction

    // Bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        if ((b >= 8'h30) && (b <= 8'h39))
        begin
            v = {1'b0, 4'(b - 8'h30)};
        end
        else if ((b >= 8'h61) && (b <= 8'h66))
        begin
            v = {1'b0, 4'(b - 8'h57)};
        end
        else if ((b >= 8'h41) && (b <= 8'h46))
        begin
            v = {1'b0, 4'(b - 8'h37)};
        end
        else
        begin
            v = 5'h10;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### src/csv_text_field_unescaper.sv
// Unescapes the bytes of a quoted CSV text stream, one byte per beat.
// Input: s_tvalid/s_tready/s_tdata carry one raw text byte per beat.
// Output: m_tvalid/m_tready/m_tdata/m_tlast carry one decoded byte per beat;
// m_tlast high marks the end of a field, and m_tdata is then zero.
// Unescaped quotes and backslashes that are not trail bytes, the x or s after
// a backslash and the byte after its x give no beat; all other bytes give one.
// Configuration: cfg_valid/cfg_ready/cfg_data write the small-font offset;
// cfg_ready is always high. Write it only while the block is idle.
// Timing: an accepted byte is held in an input register and decoded from
// it into the output register when that register can take it; a stall
// keeps it waiting. Throughput is one byte per cycle while the output
// is not stalled.
// Reset: clears the parser state, both stage valids, and sets the offset to 96.
// Stall: while m_tready is low with a result waiting, the input register
// still drains bytes that give no output; a byte that gives output waits,
// and s_tready falls only when the input register is full and cannot move.
`default_nettype none

module csv_text_field_unescaper
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic [7:0]        small_offset_reg;
    logic              can_load;
    logic              advance;
    ctfu_pkg::result_t result;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (can_load || !result.valid);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_offset_reg <= ctfu_pkg::SMALL_OFFSET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            small_offset_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    ctfu_parser u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (in_valid_reg),
        .advance      (advance),
        .in_byte      (in_byte_reg),
        .small_offset (small_offset_reg),
        .result       (result)
    );

    ctfu_out_reg u_out_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### src/ctfu_parser.sv
`default_nettype none

module ctfu_parser
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire logic              advance,
    input  wire logic [7:0]        in_byte,
    input  wire logic [7:0]        small_offset,
    output ctfu_pkg::result_t      result
);

    ctfu_pkg::phase_t phase_reg, phase_next;
    logic             quoted_reg, quoted_next;
    logic             small_mode_reg, small_mode_next;
    logic [3:0]       hex_high_reg, hex_high_next;
    logic             hex_stopped_reg, hex_stopped_next;

    logic       emit;
    logic [7:0] emit_data;
    logic       emit_last;
    logic [4:0] hex_v;
    logic [7:0] shifted_byte;

    assign hex_v        = ctfu_pkg::hex_value(in_byte);
    assign shifted_byte = in_byte + small_offset;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= ctfu_pkg::PH_NORMAL;
            quoted_reg      <= 1'b0;
            small_mode_reg  <= 1'b0;
            hex_high_reg    <= 4'h0;
            hex_stopped_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            quoted_reg      <= quoted_next;
            small_mode_reg  <= small_mode_next;
            hex_high_reg    <= hex_high_next;
            hex_stopped_reg <= hex_stopped_next;
        end
    end

    always_comb
    begin
        phase_next       = ctfu_pkg::PH_NORMAL;
        quoted_next      = quoted_reg;
        small_mode_next  = small_mode_reg;
        hex_high_next    = hex_high_reg;
        hex_stopped_next = hex_stopped_reg;
        emit             = 1'b0;
        emit_data        = 8'h00;
        emit_last        = 1'b0;

        unique case (phase_reg)
            ctfu_pkg::PH_TRAIL:
            begin
                emit      = 1'b1;
                emit_data = in_byte;
            end
            ctfu_pkg::PH_ESCAPE:
            begin
                priority if (in_byte == ctfu_pkg::CH_LOWER_X)
                begin
                    phase_next = ctfu_pkg::PH_HEX1;
                end
                else if (in_byte == ctfu_pkg::CH_LOWER_S)
                begin
                    small_mode_next = !small_mode_reg;
                end
                else
                begin
                    emit      = 1'b1;
                    emit_data = in_byte;
                end
            end
            ctfu_pkg::PH_HEX1:
            begin
                hex_stopped_next = hex_v[4];
                hex_high_next    = hex_v[4] ? 4'h0 : hex_v[3:0];
                phase_next       = ctfu_pkg::PH_HEX2;
            end
            ctfu_pkg::PH_HEX2:
            begin
                emit = 1'b1;
                priority if (hex_stopped_reg)
                begin
                    emit_data = 8'h00;
                end
                else if (hex_v[4])
                begin
                    emit_data = {4'h0, hex_high_reg};
                end
                else
                begin
                    emit_data = {hex_high_reg, hex_v[3:0]};
                end
            end
            default:
            begin
                priority if (ctfu_pkg::is_lead(in_byte))
                begin
                    phase_next = ctfu_pkg::PH_TRAIL;
                    emit       = 1'b1;
                    emit_data  = in_byte;
                end
                else if (in_byte == ctfu_pkg::CH_QUOTE)
                begin
                    quoted_next = !quoted_reg;
                end
                else if (in_byte == ctfu_pkg::CH_BACKSLASH)
                begin
                    phase_next = ctfu_pkg::PH_ESCAPE;
                end
                else if (!quoted_reg && ((in_byte == ctfu_pkg::CH_COMMA) ||
                                         (in_byte == ctfu_pkg::CH_NEWLINE)))
                begin
                    quoted_next     = 1'b0;
                    small_mode_next = 1'b0;
                    emit            = 1'b1;
                    emit_last       = 1'b1;
                end
                else
                begin
                    emit      = 1'b1;
                    emit_data = small_mode_reg ? shifted_byte : in_byte;
                end
            end
        endcase
    end

    assign result.valid = item_valid && emit;
    assign result.data  = emit_data;
    assign result.last  = emit_last;

endmodule

`default_nettype wire

### src/ctfu_out_reg.sv
`default_nettype none

module ctfu_out_reg
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctfu_pkg::result_t result,
    output logic                   can_load,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    assign can_load = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid && can_load)
        begin
            data_reg <= result.data;
            last_reg <= result.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

### src/ctfu_checker.sv
`default_nettype none

module ctfu_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic [7:0] s_tdata,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic       cfg_valid,
    input wire logic       cfg_ready,
    input wire logic [7:0] cfg_data
);

    // A stalled output beat holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output beat changed while stalled");

    // A field end beat carries a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata == 8'h00))
        else $error("field end beat with nonzero data");

    // With the output register empty the input side is never blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // A new output beat needs an input beat accepted before it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("output beat without pending input");

    // The configuration channel never back-pressures.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

    logic unused_ok;
    assign unused_ok = ^{s_tdata, cfg_data};

endmodule

bind csv_text_field_unescaper ctfu_checker u_ctfu_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);

`default_nettype wire

### test/unescape_checker.sv
module unescape_checker
    import ctfu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } decoded_t;

    decoded_t   decoded_q[$];
    decoded_t   want;
    decoded_t   res;
    logic       emit;

    logic [7:0] offset;
    phase_t     parse_phase;
    logic       quoted;
    logic       small_mode;
    logic [3:0] hex_high;
    logic       hex_stopped;

    function automatic logic sjis_lead(input logic [7:0] b);
        return (b inside {[LEAD1_LO:LEAD1_HI]}) || (b inside {[LEAD2_LO:LEAD2_HI]});
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        logic [7:0] folded;
        folded = b | 8'h20;
        return (b >= "0" && b <= "9") || (folded >= "a" && folded <= "f");
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] b);
        return (b <= "9") ? b[3:0] : 4'(b[3:0] + 4'd9);
    endfunction

    task automatic decode_byte(input logic [7:0] b, output logic got, output decoded_t r);
        got = 1'b1;
        r.data = b;
        r.last = 1'b0;
        case (parse_phase)
            PH_TRAIL:
            begin
                parse_phase = PH_NORMAL;
            end
            PH_ESCAPE:
            begin
                if (b == CH_LOWER_X)
                begin
                    parse_phase = PH_HEX1;
                    got = 1'b0;
                end
                else
                begin
                    parse_phase = PH_NORMAL;
                    if (b == CH_LOWER_S)
                    begin
                        small_mode = !small_mode;
                        got = 1'b0;
                    end
                end
            end
            PH_HEX1:
            begin
                hex_stopped = !is_hex(b);
                hex_high = hex_stopped ? 4'd0 : hex_nibble(b);
                parse_phase = PH_HEX2;
                got = 1'b0;
            end
            PH_HEX2:
            begin
                parse_phase = PH_NORMAL;
                if (hex_stopped)
                    r.data = 8'd0;
                else if (!is_hex(b))
                    r.data = {4'd0, hex_high};
                else
                    r.data = {hex_high, hex_nibble(b)};
            end
            default:
            begin
                parse_phase = PH_NORMAL;
                if (sjis_lead(b))
                begin
                    parse_phase = PH_TRAIL;
                end
                else if (b == CH_QUOTE)
                begin
                    quoted = !quoted;
                    got = 1'b0;
                end
                else if (b == CH_BACKSLASH)
                begin
                    parse_phase = PH_ESCAPE;
                    got = 1'b0;
                end
                else if (!quoted && (b == CH_COMMA || b == CH_NEWLINE))
                begin
                    small_mode = 1'b0;
                    r.data = 8'd0;
                    r.last = 1'b1;
                end
                else if (small_mode)
                begin
                    r.data = 8'(b + offset);
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decoded_q.delete();
            offset = SMALL_OFFSET_RESET;
            parse_phase = PH_NORMAL;
            quoted = 1'b0;
            small_mode = 1'b0;
            hex_high = 4'd0;
            hex_stopped = 1'b0;
            pending = 0;
        end
        else
        begin
            // An output beat always comes from an input accepted in an earlier cycle.
            if (m_tvalid && m_tready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected output beat: out_byte %0h end_of_field %0b",
                           m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (m_tdata !== want.data)
                    begin
                        $error("out_byte mismatch: expected %0h, actual %0h", want.data, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("end_of_field mismatch: expected %0b, actual %0b",
                               want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                offset = cfg_data;
            if (s_tvalid && s_tready)
            begin
                decode_byte(s_tdata, emit, res);
                if (emit)
                    decoded_q = {decoded_q, res};
            end
            pending = decoded_q.size();
        end
    end

endmodule

### test/tb.sv
module tb;
    import ctfu_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 400;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    int         fail_count;
    int         pending;
    int         items_sent;
    int         stall_cycles;
    bit         idle_on;

    csv_text_field_unescaper DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    unescape_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #1 clk = ~clk;

    always @(negedge clk)
    begin
        m_tready <= !(idle_on && $urandom_range(0, 99) < 25);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("csv_text_field_unescaper test failed");
                $finish;
            end
        end
    end

    // Every task below is entered and left just after a falling edge.
    task automatic send_byte(input logic [7:0] b);
        while (idle_on && $urandom_range(0, 99) < 25)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_offset(input logic [7:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char();
        logic [3:0] n;
        n = 4'($urandom_range(0, 15));
        if (n < 10)
            return 8'("0" + n);
        return $urandom_range(0, 1) ? 8'("a" + n - 10) : 8'("A" + n - 10);
    endfunction

    task automatic send_token();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            send_byte(8'($urandom_range(8'h20, 8'h7E)));
        end
        else if (pick < 40)
        begin
            send_byte($urandom_range(0, 1) ? 8'($urandom_range(LEAD1_LO, LEAD1_HI))
                                           : 8'($urandom_range(LEAD2_LO, LEAD2_HI)));
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 50)
        begin
            send_byte(CH_QUOTE);
        end
        else if (pick < 58)
        begin
            send_byte(CH_BACKSLASH);
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 64)
        begin
            send_byte(CH_BACKSLASH);
            send_byte(CH_LOWER_S);
        end
        else if (pick < 76)
        begin
            send_byte(CH_BACKSLASH);
            send_byte(CH_LOWER_X);
            send_byte(($urandom_range(0, 99) < 80) ? hex_char() : 8'($urandom_range(0, 255)));
            send_byte(($urandom_range(0, 99) < 80) ? hex_char() : 8'($urandom_range(0, 255)));
        end
        else if (pick < 88)
        begin
            send_byte($urandom_range(0, 1) ? CH_COMMA : CH_NEWLINE);
        end
        else
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(input int count, input bit with_idle);
        int target;
        target = items_sent + count;
        idle_on = with_idle;
        while (items_sent < target)
            send_token();
        idle_on = 1'b1;
    endtask

    initial
    begin
        logic [7:0] directed[$];
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        m_tready = 1'b1;
        cfg_valid = 1'b0;
        cfg_data = 8'd0;
        idle_on = 1'b1;
        items_sent = 0;
        stall_cycles = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed = '{8'h00, 8'hFF, 8'h81, CH_QUOTE, 8'hEF, CH_COMMA,
                     CH_QUOTE, CH_COMMA, CH_QUOTE,
                     CH_BACKSLASH, CH_LOWER_X, "a", "F",
                     CH_BACKSLASH, CH_LOWER_X, "g", "1",
                     CH_BACKSLASH, CH_LOWER_X, "9", "Z",
                     CH_BACKSLASH, CH_COMMA,
                     CH_BACKSLASH, CH_LOWER_S, 8'h7F, 8'hE0, CH_BACKSLASH, CH_NEWLINE};
        foreach (directed[i])
            send_byte(directed[i]);

        write_offset(8'd0);
        run_random(PHASE_ITEMS, 1'b1);
        write_offset(8'd255);
        run_random(PHASE_ITEMS, 1'b0);
        write_offset(8'($urandom_range(1, 254)));
        run_random(PHASE_ITEMS / 2, 1'b1);
        wait_drained();
        run_random(PHASE_ITEMS / 2, 1'b1);
        write_offset(8'($urandom_range(0, 255)));
        run_random(PHASE_ITEMS, 1'b1);

        wait_drained();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("csv_text_field_unescaper test passed");
        else
            $display("csv_text_field_unescaper test failed");
        $finish;
    end

endmodule
